// File: hdl/sbts_pkg.sv
// Shared types and constants for the smoothstep bilinear texture sampler.
package sbts_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int MAX_DIM     = 256;
  localparam int DIM_W       = 9;
  localparam int IDX_W       = 8;
  localparam int ADDR_W      = 16;
  localparam int STORE_DEPTH = 65536;
  localparam int TEXEL_W     = 24;
  localparam int WT_W        = 2 * FRAC_BITS + 1;
  localparam int PROD_W      = WT_W + 8;
  localparam int SUM_W       = PROD_W + 1;

  // Register indexes on the configuration port
  localparam logic REG_TEX_WIDTH  = 1'b0;
  localparam logic REG_TEX_HEIGHT = 1'b1;

  // Item kinds
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic [FRAC_BITS+1:0] THREE_ONE = (FRAC_BITS + 2)'(3 * (1 << FRAC_BITS));
  localparam logic [FRAC_BITS:0]   ONE_FX    = (FRAC_BITS + 1)'(1 << FRAC_BITS);
  localparam logic [SUM_W-1:0]     ROUND_HALF = SUM_W'(64'd1 << (2 * FRAC_BITS - 1));

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [TEXEL_W-1:0] texel_t;

  typedef struct packed {
    logic   we;
    addr_t  addr;
    texel_t data;
  } wr_req_t;

endpackage

// File: hdl/sbts_texmem.sv
// Texel store: two mirrored banks, each one write and two registered reads.
module sbts_texmem (
  input  logic                  clk,
  input  logic                  en,
  input  sbts_pkg::wr_req_t     wr,
  input  sbts_pkg::addr_t [3:0] raddr,
  output sbts_pkg::texel_t [3:0] rdata
);

  sbts_pkg::texel_t bank_a [sbts_pkg::STORE_DEPTH];
  sbts_pkg::texel_t bank_b [sbts_pkg::STORE_DEPTH];

  sbts_pkg::texel_t rd0_r, rd1_r, rd2_r, rd3_r;

  always_ff @(posedge clk) begin
    if (en && wr.we) begin
      bank_a[wr.addr] <= wr.data;
    end
    if (en) begin
      rd0_r <= bank_a[raddr[0]];
      rd1_r <= bank_a[raddr[1]];
    end
  end

  always_ff @(posedge clk) begin
    if (en && wr.we) begin
      bank_b[wr.addr] <= wr.data;
    end
    if (en) begin
      rd2_r <= bank_b[raddr[2]];
      rd3_r <= bank_b[raddr[3]];
    end
  end

  assign rdata[0] = rd0_r;
  assign rdata[1] = rd1_r;
  assign rdata[2] = rd2_r;
  assign rdata[3] = rd3_r;

endmodule

// File: hdl/smoothstep_bilinear_texture_sampler_core.sv
// Top level of the smoothstep bilinear texture sampler pipeline.
//
// Usage:
//   Configure tex_width / tex_height through cfg_we, cfg_index, cfg_wdata
//   while the block is idle. A zero in either means no texture: every sample
//   then returns white. Values above 256 are treated as 256.
//   Input items (in_valid / in_ready) either write one texel (in_mode = 0)
//   or sample the texture at Q16.16 coords u, v (in_mode = 1). Only the
//   fractional parts of the coords count; the texture wraps at its edges.
//   Write items make no result; each sample item makes one RGB result on
//   out_valid / out_ready.
// Throughput and pipeline:
//   One item per cycle unless stalled. A sample result is built after
//   its item is accepted: coordinate scale, smoothstep square, smoothstep
//   cubic and store read, weight product, channel products, sum and round.
//   Four texel reads per cycle come from two mirrored store banks, each
//   with two read ports. Writes enter the store at the read stage, so
//   samples see exactly the writes accepted before them.
// Reset clears all valid bits and both dimension registers; the store
//   holds no defined content until written.
// Stall: while out_valid is high and out_ready low the whole pipeline
//   holds, in_ready drops, and nothing is lost or repeated.
module smoothstep_bilinear_texture_sampler_core (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_wdata,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [15:0] in_texel_address,
  input  logic [7:0]  in_texel_red,
  input  logic [7:0]  in_texel_green,
  input  logic [7:0]  in_texel_blue,
  input  logic signed [31:0] in_coord_u,
  input  logic signed [31:0] in_coord_v,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue
);

  localparam int FB = sbts_pkg::FRAC_BITS;
  localparam int DW = sbts_pkg::DIM_W;
  localparam int IW = sbts_pkg::IDX_W;

  // Configuration registers
  logic [DW-1:0] tex_width_r, tex_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= '0;
      tex_height_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sbts_pkg::REG_TEX_WIDTH:  tex_width_r  <= cfg_wdata;
        sbts_pkg::REG_TEX_HEIGHT: tex_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Whole-pipeline advance; an empty or draining output lets everything move
  logic out_valid_r;
  logic en;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Clamp dimensions to the largest texture
  logic [DW-1:0] w_clamp, h_clamp;
  assign w_clamp = (tex_width_r  > DW'(sbts_pkg::MAX_DIM)) ? DW'(sbts_pkg::MAX_DIM) : tex_width_r;
  assign h_clamp = (tex_height_r > DW'(sbts_pkg::MAX_DIM)) ? DW'(sbts_pkg::MAX_DIM) : tex_height_r;

  // ---------------- stage 1: captured item ----------------
  logic                  v1_r, mode1_r, zero1_r;
  sbts_pkg::addr_t       addr1_r;
  sbts_pkg::texel_t      rgb1_r;
  logic [FB-1:0]         fu1_r, fv1_r;
  logic [DW-1:0]         w1_r, h1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1_r <= in_mode;
      zero1_r <= (w_clamp == '0) || (h_clamp == '0);
      addr1_r <= in_texel_address;
      rgb1_r  <= {in_texel_red, in_texel_green, in_texel_blue};
      fu1_r   <= in_coord_u[FB-1:0];
      fv1_r   <= in_coord_v[FB-1:0];
      w1_r    <= w_clamp;
      h1_r    <= h_clamp;
    end
  end

  // Scale fraction by dimension
  logic [FB+DW-1:0] pu_nxt, pv_nxt;
  assign pu_nxt = fu1_r * w1_r;
  assign pv_nxt = fv1_r * h1_r;

  // ---------------- stage 2: index and fraction ----------------
  logic                  v2_r, mode2_r, zero2_r;
  sbts_pkg::addr_t       addr2_r;
  sbts_pkg::texel_t      rgb2_r;
  logic [FB+DW-1:0]      pu2_r, pv2_r;
  logic [DW-1:0]         w2_r, h2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode2_r <= mode1_r;
      zero2_r <= zero1_r;
      addr2_r <= addr1_r;
      rgb2_r  <= rgb1_r;
      pu2_r   <= pu_nxt;
      pv2_r   <= pv_nxt;
      w2_r    <= w1_r;
      h2_r    <= h1_r;
    end
  end

  logic [IW-1:0]     iu0, iu1, jv0, jv1;
  logic [FB-1:0]     gu, gv;
  logic [2*FB-1:0]   gu_sq, gv_sq;
  logic [FB+1:0]     tu_nxt, tv_nxt;
  logic [DW+IW-1:0]  row0, row1;
  sbts_pkg::addr_t [3:0] ra_nxt;

  assign iu0 = pu2_r[FB+IW-1:FB];
  assign jv0 = pv2_r[FB+IW-1:FB];
  assign gu  = pu2_r[FB-1:0];
  assign gv  = pv2_r[FB-1:0];
  // Right and lower neighbors wrap to zero at the far edge
  assign iu1 = ({1'b0, iu0} + DW'(1) == w2_r) ? '0 : iu0 + IW'(1);
  assign jv1 = ({1'b0, jv0} + DW'(1) == h2_r) ? '0 : jv0 + IW'(1);

  assign gu_sq  = gu * gu;
  assign gv_sq  = gv * gv;
  assign tu_nxt = sbts_pkg::THREE_ONE - {1'b0, gu, 1'b0};
  assign tv_nxt = sbts_pkg::THREE_ONE - {1'b0, gv, 1'b0};

  assign row0 = jv0 * w2_r;
  assign row1 = jv1 * w2_r;
  assign ra_nxt[0] = sbts_pkg::ADDR_W'(row0 + (DW+IW)'(iu0));
  assign ra_nxt[1] = sbts_pkg::ADDR_W'(row0 + (DW+IW)'(iu1));
  assign ra_nxt[2] = sbts_pkg::ADDR_W'(row1 + (DW+IW)'(iu0));
  assign ra_nxt[3] = sbts_pkg::ADDR_W'(row1 + (DW+IW)'(iu1));

  // ---------------- stage 3: store access, smoothstep cubic ----------------
  logic                  v3_r, mode3_r, zero3_r;
  sbts_pkg::addr_t       addr3_r;
  sbts_pkg::texel_t      rgb3_r;
  logic [FB-1:0]         squ3_r, sqv3_r;
  logic [FB+1:0]         tu3_r, tv3_r;
  sbts_pkg::addr_t [3:0] ra3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode3_r <= mode2_r;
      zero3_r <= zero2_r;
      addr3_r <= addr2_r;
      rgb3_r  <= rgb2_r;
      squ3_r  <= gu_sq[2*FB-1:FB];
      sqv3_r  <= gv_sq[2*FB-1:FB];
      tu3_r   <= tu_nxt;
      tv3_r   <= tv_nxt;
      ra3_r   <= ra_nxt;
    end
  end

  logic [2*FB+1:0] su_prod, sv_prod;
  assign su_prod = squ3_r * tu3_r;
  assign sv_prod = sqv3_r * tv3_r;

  sbts_pkg::wr_req_t      wr_req;
  sbts_pkg::texel_t [3:0] texel_rd;

  assign wr_req.we   = v3_r && (mode3_r == sbts_pkg::MODE_WRITE);
  assign wr_req.addr = addr3_r;
  assign wr_req.data = rgb3_r;

  sbts_texmem u_texmem (
    .clk   (clk),
    .en    (en),
    .wr    (wr_req),
    .raddr (ra3_r),
    .rdata (texel_rd)
  );

  // ---------------- stage 4: texels in, weights ----------------
  logic          v4_r, mode4_r, zero4_r;
  logic [FB-1:0] su4_r, sv4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode4_r <= mode3_r;
      zero4_r <= zero3_r;
      su4_r   <= su_prod[2*FB-1:FB];
      sv4_r   <= sv_prod[2*FB-1:FB];
    end
  end

  logic [FB:0]   su_c, sv_c;
  logic [2*FB+1:0] wt_full [4];
  assign su_c = sbts_pkg::ONE_FX - {1'b0, su4_r};
  assign sv_c = sbts_pkg::ONE_FX - {1'b0, sv4_r};
  assign wt_full[0] = su_c * sv_c;
  assign wt_full[1] = {1'b0, su4_r} * sv_c;
  assign wt_full[2] = su_c * {1'b0, sv4_r};
  assign wt_full[3] = {1'b0, su4_r} * {1'b0, sv4_r};

  // ---------------- stage 5: weights and texels ----------------
  logic                  v5_r, mode5_r, zero5_r;
  logic [sbts_pkg::WT_W-1:0] wt5_r [4];
  sbts_pkg::texel_t      tex5_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode5_r <= mode4_r;
      zero5_r <= zero4_r;
      for (int k = 0; k < 4; k++) begin
        wt5_r[k]  <= wt_full[k][sbts_pkg::WT_W-1:0];
        tex5_r[k] <= texel_rd[k];
      end
    end
  end

  // ---------------- stage 6: channel products ----------------
  logic v6_r, mode6_r, zero6_r;
  logic [sbts_pkg::PROD_W-1:0] prod6_r [3][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode6_r <= mode5_r;
      zero6_r <= zero5_r;
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 4; k++) begin
          prod6_r[c][k] <= wt5_r[k] * tex5_r[k][23-8*c -: 8];
        end
      end
    end
  end

  // Sum, round half up, saturate; white when there is no texture
  logic [sbts_pkg::SUM_W-1:0] acc [3];
  logic [7:0] chan_nxt [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = sbts_pkg::SUM_W'(prod6_r[c][0]) + sbts_pkg::SUM_W'(prod6_r[c][1])
             + sbts_pkg::SUM_W'(prod6_r[c][2]) + sbts_pkg::SUM_W'(prod6_r[c][3])
             + sbts_pkg::ROUND_HALF;
      if (zero6_r) begin
        chan_nxt[c] = 8'hFF;
      end else if (acc[c][sbts_pkg::SUM_W-1:2*FB+8] != '0) begin
        chan_nxt[c] = 8'hFF;
      end else begin
        chan_nxt[c] = acc[c][2*FB+7:2*FB];
      end
    end
  end

  // ---------------- stage 7: output register ----------------
  logic [7:0] red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v6_r && (mode6_r == sbts_pkg::MODE_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= chan_nxt[0];
      green_r <= chan_nxt[1];
      blue_r  <= chan_nxt[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  // ---------------- assertions ----------------
  // Bilinear weights always sum to exactly one
  a_wt_sum: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> ((sbts_pkg::WT_W + 2)'(wt5_r[0]) + (sbts_pkg::WT_W + 2)'(wt5_r[1])
            + (sbts_pkg::WT_W + 2)'(wt5_r[2]) + (sbts_pkg::WT_W + 2)'(wt5_r[3])
            == (sbts_pkg::WT_W + 2)'(64'd1 << (2 * FB))))
    else $error("bilinear weights do not sum to one");

  // A stalled pipeline holds its valid bits (checked on stages 3 and 6)
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(v3_r) && $stable(v6_r)))
    else $error("pipeline moved during stall");

  // A sample with no texture comes out white
  a_white: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v6_r && mode6_r == sbts_pkg::MODE_SAMPLE && zero6_r)
      |=> (out_valid_r && red_r == 8'hFF && green_r == 8'hFF && blue_r == 8'hFF))
    else $error("no-texture sample not white");

  // Write items never reach the result channel
  a_no_write_out: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v6_r && mode6_r == sbts_pkg::MODE_WRITE) |=> !out_valid_r)
    else $error("write item produced a result");

endmodule
